>>> src/blal_pkg.sv
// ----------------------------------------------------------------------------
// blal_pkg: shared types and constants for the bounded array list engine
// Command and status codes, field widths, cell control and FSM state types.
// ----------------------------------------------------------------------------
package blal_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam int CMD_W = 3;
    localparam int POS_W = 6;
    localparam int VAL_W = 32;
    localparam int STS_W = 2;
    localparam int IDX_W = 5;
    localparam int LEN_W = 6;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 3'd0,
        CMD_REM_KEY  = 3'd1,
        CMD_REM_IDX  = 3'd2,
        CMD_FIND_KEY = 3'd3,
        CMD_FIND_IDX = 3'd4
    } cmd_t;

    typedef enum logic [STS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_BADPOS = 2'd2,
        STATUS_NOKEY  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_UP,
        CELL_DOWN
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     cmp;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_APPLY = 2'b10
    } state_t;

endpackage

>>> src/bounded_array_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_array_list_engine: ordered list of unsigned 32-bit words in a row of cells
// Insert, remove by key or index, find by key or index; every result beat
// reports the status and the list length after the command.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload (tdata, lowest bit first)
//  --------+-----+---------------------------------------------------------
//  s_      | in  | command[2:0], position[8:3], item_value[40:9], zero pad
//  m_      | out | status[1:0], found_index[6:2], read_value[38:7],
//          |     | list_length[44:39], zero pad
//
//  For each command, the accept edge latches the command and has
//  every cell compare its entry against the key at once; the apply edge
//  encodes the first match, shifts or loads the cells and loads the result.
//  aresetn (synchronous, active low) clears the length, the FSM and m_tvalid;
//  cell contents are not cleared and are only ever read below the length.
//  A result beat waits in the output register; the next command is accepted
//  meanwhile, and only its apply step stalls while m_ holds an untaken beat.
//
module bounded_array_list_engine #(
    parameter int CAPACITY = blal_pkg::CAPACITY_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // command[2:0], position[8:3], item_value[40:9]
    input  logic [blal_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // status[1:0], found_index[6:2], read_value[38:7], list_length[44:39]
    output logic [blal_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready
);

    localparam int IW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // compare width: holds the length, any position and any cell index
    localparam int CMP_W = (CNT_W > blal_pkg::POS_W) ? CNT_W : blal_pkg::POS_W;

    // ---------------------------------------------------------------- control
    blal_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [blal_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // latched command
    blal_pkg::cmd_t               cmd_reg;
    logic [blal_pkg::POS_W-1:0]   pos_reg;
    logic [blal_pkg::VAL_W-1:0]   val_reg;

    logic s_accept;
    logic apply_go;

    assign s_tready = (state_reg == blal_pkg::S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    // apply only when the output register is free or being emptied
    assign apply_go = (state_reg == blal_pkg::S_APPLY) && (!m_tvalid_reg || m_tready);

    // ---------------------------------------------------------------- cells
    blal_pkg::cell_ctrl_t         ctrl     [CAPACITY];
    logic [blal_pkg::VAL_W-1:0]   cell_val [CAPACITY];
    logic [CAPACITY-1:0]          cell_match;
    logic [CAPACITY-1:0]          live_match;
    logic [blal_pkg::VAL_W-1:0]   key;

    // compare against the incoming key on the accept beat
    assign key = s_tdata[40:9];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [blal_pkg::VAL_W-1:0] lower_v;
        logic [blal_pkg::VAL_W-1:0] upper_v;

        if (g == 0) begin : g_lo
            assign lower_v = '0;
        end else begin : g_lo
            assign lower_v = cell_val[g-1];
        end
        // top cell shifting down keeps its own value; it lies past the length
        if (g == CAPACITY - 1) begin : g_hi
            assign upper_v = cell_val[g];
        end else begin : g_hi
            assign upper_v = cell_val[g+1];
        end

        blal_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl[g]),
            .key         (key),
            .load_value  (val_reg),
            .lower_value (lower_v),
            .upper_value (upper_v),
            .cell_value  (cell_val[g]),
            .cell_match  (cell_match[g])
        );
    end

    // ---------------------------------------------------------------- search
    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] pos_ext;

    assign count_ext = CMP_W'(count_reg);
    assign pos_ext   = CMP_W'(pos_reg);

    // drop matches past the current length
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            live_match[i] = cell_match[i] && (CMP_W'(i) < count_ext);
        end
    end

    logic          hit;
    logic [IW-1:0] first_idx;

    blal_find #(
        .N  (CAPACITY),
        .IW (IW)
    ) u_find (
        .match       (live_match),
        .hit         (hit),
        .first_index (first_idx)
    );

    // entry at the requested position
    logic [blal_pkg::VAL_W-1:0] pos_value;

    always_comb begin
        pos_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (CMP_W'(i) == pos_ext) begin
                pos_value = pos_value | cell_val[i];
            end
        end
    end

    // ---------------------------------------------------------------- decode
    blal_pkg::status_t            status;
    logic [CMP_W-1:0]             found_ext;
    logic [blal_pkg::VAL_W-1:0]   read_value;
    logic                         ins_ok;
    logic                         del_ok;
    logic [CMP_W-1:0]             del_idx;
    logic [CMP_W-1:0]             len_ext;

    always_comb begin
        status     = blal_pkg::STATUS_BADPOS;
        found_ext  = '0;
        read_value = '0;
        ins_ok     = 1'b0;
        del_ok     = 1'b0;
        del_idx    = pos_ext;
        case (cmd_reg)
            blal_pkg::CMD_INSERT: begin
                // fullness wins over a bad position
                if (count_ext == CMP_W'(CAPACITY)) begin
                    status = blal_pkg::STATUS_FULL;
                end else if (pos_ext > count_ext) begin
                    status = blal_pkg::STATUS_BADPOS;
                end else begin
                    status = blal_pkg::STATUS_OK;
                    ins_ok = 1'b1;
                end
            end
            blal_pkg::CMD_REM_KEY: begin
                if (hit) begin
                    status  = blal_pkg::STATUS_OK;
                    del_ok  = 1'b1;
                    del_idx = CMP_W'(first_idx);
                end else begin
                    status = blal_pkg::STATUS_NOKEY;
                end
            end
            blal_pkg::CMD_REM_IDX: begin
                if (pos_ext < count_ext) begin
                    status = blal_pkg::STATUS_OK;
                    del_ok = 1'b1;
                end
            end
            blal_pkg::CMD_FIND_KEY: begin
                if (hit) begin
                    status    = blal_pkg::STATUS_OK;
                    found_ext = CMP_W'(first_idx);
                end else begin
                    status = blal_pkg::STATUS_NOKEY;
                end
            end
            blal_pkg::CMD_FIND_IDX: begin
                if (pos_ext < count_ext) begin
                    status     = blal_pkg::STATUS_OK;
                    read_value = pos_value;
                end
            end
            default: begin
                status = blal_pkg::STATUS_BADPOS;
            end
        endcase
    end

    // cell controls: insert opens a gap at pos, delete closes the gap at del_idx
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            ctrl[i].cmp = s_accept;
            ctrl[i].op  = blal_pkg::CELL_HOLD;
            if (apply_go && ins_ok) begin
                if (CMP_W'(i) == pos_ext) begin
                    ctrl[i].op = blal_pkg::CELL_LOAD;
                end else if (CMP_W'(i) > pos_ext) begin
                    ctrl[i].op = blal_pkg::CELL_UP;
                end
            end else if (apply_go && del_ok) begin
                if (CMP_W'(i) >= del_idx) begin
                    ctrl[i].op = blal_pkg::CELL_DOWN;
                end
            end
        end
    end

    // ---------------------------------------------------------------- next state
    always_comb begin
        count_next = count_reg;
        if (apply_go && ins_ok) begin
            count_next = count_reg + CNT_W'(1);
        end else if (apply_go && del_ok) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign len_ext = CMP_W'(count_next);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            blal_pkg::S_IDLE: begin
                if (s_accept) begin
                    state_next = blal_pkg::S_APPLY;
                end
            end
            blal_pkg::S_APPLY: begin
                if (apply_go) begin
                    state_next = blal_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = blal_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (apply_go) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= blal_pkg::S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg <= blal_pkg::cmd_t'(s_tdata[2:0]);
            pos_reg <= s_tdata[8:3];
            val_reg <= s_tdata[40:9];
        end
        if (apply_go) begin
            m_tdata_reg <= {3'b000,
                            len_ext[blal_pkg::LEN_W-1:0],
                            read_value,
                            found_ext[blal_pkg::IDX_W-1:0],
                            status};
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    // ---------------------------------------------------------------- checks
`ifndef SYNTH
    // length never passes capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= CMP_W'(CAPACITY))
        else $error("list length above capacity");

    // an accepted beat always moves to apply
    a_accept_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == blal_pkg::S_APPLY))
        else $error("accepted command did not reach apply");

    // each apply delivers a result beat
    a_apply_out: assert property (@(posedge aclk) disable iff (!aresetn)
        apply_go |=> m_tvalid_reg)
        else $error("apply without result beat");

    // length only changes during apply, by one
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !apply_go |=> (count_reg == $past(count_reg)))
        else $error("length changed outside apply");
`endif

endmodule

>>> src/blal_cell.sv
// ----------------------------------------------------------------------------
// blal_cell: one list slot
// Holds one entry, compares it against the search key, and loads, shifts up
// from its lower neighbor or shifts down from its upper neighbor.
// ----------------------------------------------------------------------------
module blal_cell (
    input  logic                      aclk,
    input  blal_pkg::cell_ctrl_t      ctrl,
    input  logic [blal_pkg::VAL_W-1:0] key,
    input  logic [blal_pkg::VAL_W-1:0] load_value,
    input  logic [blal_pkg::VAL_W-1:0] lower_value,
    input  logic [blal_pkg::VAL_W-1:0] upper_value,
    output logic [blal_pkg::VAL_W-1:0] cell_value,
    output logic                      cell_match
);

    logic [blal_pkg::VAL_W-1:0] value_reg;
    logic                       match_reg;

    always_ff @(posedge aclk) begin
        case (ctrl.op)
            blal_pkg::CELL_LOAD: value_reg <= load_value;
            blal_pkg::CELL_UP:   value_reg <= lower_value;
            blal_pkg::CELL_DOWN: value_reg <= upper_value;
            default:             value_reg <= value_reg;
        endcase
        // latch the compare on the accepted beat; hold it through apply
        if (ctrl.cmp) begin
            match_reg <= (value_reg == key);
        end
    end

    assign cell_value = value_reg;
    assign cell_match = match_reg;

endmodule

>>> src/blal_find.sv
// ----------------------------------------------------------------------------
// blal_find: first-match priority encoder
// Isolates the lowest set match bit and encodes its position.
// ----------------------------------------------------------------------------
module blal_find #(
    parameter int N  = blal_pkg::CAPACITY_DEF,
    parameter int IW = $clog2(N)
) (
    input  logic [N-1:0]  match,
    output logic          hit,
    output logic [IW-1:0] first_index
);

    logic [N-1:0] first_onehot;

    // lowest set bit: x & -x
    assign first_onehot = match & (~match + N'(1));
    assign hit          = |match;

    always_comb begin
        first_index = '0;
        for (int i = 0; i < N; i++) begin
            if (first_onehot[i]) begin
                first_index = first_index | IW'(i);
            end
        end
    end

endmodule
